/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define TKEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked only when the enabling condition holds.
`define TKEP_ASSERT_IMP(label, cond, prop, msg) \
  `TKEP_ASSERT(label, (cond) |-> (prop), msg)

`endif

/* rtl/tkep_pkg.sv */
package tkep_pkg;

  localparam int PoolEntries = 64;
  localparam int TypeLists   = 4;
  localparam int IdxW        = $clog2(PoolEntries);
  localparam int LinkW       = IdxW + 1;
  localparam int TypeW       = 2;
  localparam int CntW        = 7;
  localparam int DataW       = 64;

  localparam logic [LinkW-1:0] NilLink = LinkW'(PoolEntries);

  typedef enum logic [2:0] {
    REQ_FIND_KEY  = 3'd0,
    REQ_FIND_HND  = 3'd1,
    REQ_INSERT    = 3'd2,
    REQ_REM_KEY   = 3'd3,
    REQ_REM_HND   = 3'd4,
    REQ_COUNT     = 3'd5,
    REQ_CLEAR     = 3'd6,
    REQ_UNKNOWN   = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_RM_UNLINK,
    ST_RM_FREE,
    ST_INS_POP,
    ST_INS_LINK,
    ST_INS_HEAD,
    ST_CLR,
    ST_EMIT
  } state_e;

endpackage

/* rtl/tkep_chan_if.sv */
interface tkep_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [1:0]  entry_type;
  logic [31:0] lookup_key;
  logic [31:0] handle_in;

  modport source (output valid, req_type, entry_type, lookup_key, handle_in, input ready);
  modport sink (input valid, req_type, entry_type, lookup_key, handle_in, output ready);
endinterface

interface tkep_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] key_out;
  logic [31:0] handle_out;
  logic [6:0]  type_count;
  logic        last;

  modport source (output valid, status, key_out, handle_out, type_count, last, input ready);
  modport sink (input valid, status, key_out, handle_out, type_count, last, output ready);
endinterface

/* rtl/tkep_ram.sv */
module tkep_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/typed_keyed_entry_pool.sv */
// Typed keyed entry pool: 64 entries, each holding a 32-bit key and a 32-bit
// handle, kept on four newest-first type lists plus a free list. One request
// is handled at a time; req_i.ready is high only while the block is idle, and
// a finished result may wait in the output register while the next request
// is taken. Entry data and the next/prev links live in three single-port-write
// RAMs with registered reads; a find or remove walk reads one entry per cycle.
// Count and unknown requests go straight to the result; insert takes a freed
// or fresh entry, writes it and links it at the head; remove unlinks and frees
// the hit; clear gives one result per cycle per removed entry when the
// output side keeps up. Per-type counts are held in registers. No clearing
// pass is needed after reset: never-used entries are handed out in index
// order by a fill counter behind a stack of released entries.
`include "assert_macros.svh"

module typed_keyed_entry_pool (
  input  logic       clk_i,
  input  logic       rst_ni,
  tkep_req_if.sink   req_i,
  tkep_rsp_if.source rsp_o
);

  localparam int IdxW  = tkep_pkg::IdxW;
  localparam int LinkW = tkep_pkg::LinkW;
  localparam int CntW  = tkep_pkg::CntW;
  localparam int DataW = tkep_pkg::DataW;
  localparam int TypeW = tkep_pkg::TypeW;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  tkep_pkg::state_e state_q, state_d;

  logic [LinkW-1:0] head_q [tkep_pkg::TypeLists];
  logic [LinkW-1:0] head_d [tkep_pkg::TypeLists];
  logic [CntW-1:0]  cnt_q  [tkep_pkg::TypeLists];
  logic [CntW-1:0]  cnt_d  [tkep_pkg::TypeLists];

  logic [LinkW-1:0] free_head_q, free_head_d;   // stack of released entries
  logic [LinkW-1:0] fresh_q, fresh_d;           // next never-used entry

  // Current request
  tkep_pkg::req_e   req_q, req_d;
  logic [TypeW-1:0] type_q, type_d;
  logic [31:0]      key_q, key_d;
  logic [31:0]      hnd_q, hnd_d;

  // Walk pointer and saved links of a hit
  logic [LinkW-1:0] cur_q, cur_d;
  logic [LinkW-1:0] slot_q, slot_d;
  logic [LinkW-1:0] nxt_q, nxt_d;
  logic [LinkW-1:0] prv_q, prv_d;

  // Staged single result
  tkep_pkg::status_e res_status_q, res_status_d;
  logic [31:0]       res_key_q, res_key_d;
  logic [31:0]       res_hnd_q, res_hnd_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [31:0]     out_key_q, out_key_d;
  logic [31:0]     out_hnd_q, out_hnd_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic            out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // Memories: {key, handle}, next link, prev link
  // ---------------------------------------------------------------------------
  logic             dw_en, nw_en, pw_en;
  logic [IdxW-1:0]  dw_addr, nw_addr, pw_addr, rd_addr;
  logic [DataW-1:0] dw_data, d_rdata;
  logic [LinkW-1:0] nw_data, pw_data, n_rdata, p_rdata;

  tkep_ram #(.Width(DataW), .Depth(tkep_pkg::PoolEntries)) u_data_ram (
    .clk_i, .we_i(dw_en), .waddr_i(dw_addr), .wdata_i(dw_data),
    .raddr_i(rd_addr), .rdata_o(d_rdata)
  );

  tkep_ram #(.Width(LinkW), .Depth(tkep_pkg::PoolEntries)) u_next_ram (
    .clk_i, .we_i(nw_en), .waddr_i(nw_addr), .wdata_i(nw_data),
    .raddr_i(rd_addr), .rdata_o(n_rdata)
  );

  tkep_ram #(.Width(LinkW), .Depth(tkep_pkg::PoolEntries)) u_prev_ram (
    .clk_i, .we_i(pw_en), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(rd_addr), .rdata_o(p_rdata)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  logic            can_emit;
  logic            in_fire;
  logic            by_hnd;
  logic            hit;
  logic [LinkW-1:0] cur_head;

  assign can_emit = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == tkep_pkg::ST_IDLE);
  assign in_fire = req_i.valid && req_i.ready;
  assign by_hnd = (req_q == tkep_pkg::REQ_FIND_HND) || (req_q == tkep_pkg::REQ_REM_HND);
  assign hit = by_hnd ? (d_rdata[31:0] == hnd_q) : (d_rdata[63:32] == key_q);
  assign cur_head = head_q[type_q];

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    free_head_d  = free_head_q;
    fresh_d      = fresh_q;
    req_d        = req_q;
    type_d       = type_q;
    key_d        = key_q;
    hnd_d        = hnd_q;
    cur_d        = cur_q;
    slot_d       = slot_q;
    nxt_d        = nxt_q;
    prv_d        = prv_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_hnd_d    = res_hnd_q;

    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_hnd_d    = out_hnd_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;

    dw_en   = 1'b0;
    dw_addr = slot_q[IdxW-1:0];
    dw_data = {key_q, hnd_q};
    nw_en   = 1'b0;
    nw_addr = slot_q[IdxW-1:0];
    nw_data = tkep_pkg::NilLink;
    pw_en   = 1'b0;
    pw_addr = slot_q[IdxW-1:0];
    pw_data = tkep_pkg::NilLink;
    rd_addr = cur_q[IdxW-1:0];

    case (state_q)
      tkep_pkg::ST_IDLE: begin
        if (in_fire) begin
          req_d        = tkep_pkg::req_e'(req_i.req_type);
          type_d       = req_i.entry_type;
          key_d        = req_i.lookup_key;
          hnd_d        = req_i.handle_in;
          res_status_d = tkep_pkg::STAT_MISS;
          res_key_d    = '0;
          res_hnd_d    = '0;
          cur_d        = head_q[req_i.entry_type];
          rd_addr      = head_q[req_i.entry_type][IdxW-1:0];
          state_d      = tkep_pkg::ST_EMIT;
          case (tkep_pkg::req_e'(req_i.req_type))
            tkep_pkg::REQ_FIND_KEY, tkep_pkg::REQ_FIND_HND,
            tkep_pkg::REQ_REM_KEY, tkep_pkg::REQ_REM_HND: begin
              if (head_q[req_i.entry_type] != tkep_pkg::NilLink) begin
                state_d = tkep_pkg::ST_WALK;
              end
            end
            tkep_pkg::REQ_CLEAR: begin
              if (head_q[req_i.entry_type] != tkep_pkg::NilLink) begin
                state_d = tkep_pkg::ST_CLR;
              end
            end
            tkep_pkg::REQ_INSERT: begin
              if (free_head_q != tkep_pkg::NilLink) begin
                cur_d   = free_head_q;
                rd_addr = free_head_q[IdxW-1:0];
                state_d = tkep_pkg::ST_INS_POP;
              end else if (fresh_q != tkep_pkg::NilLink) begin
                slot_d  = fresh_q;
                fresh_d = fresh_q + LinkW'(1);
                state_d = tkep_pkg::ST_INS_LINK;
              end else begin
                res_status_d = tkep_pkg::STAT_FULL;
              end
            end
            tkep_pkg::REQ_COUNT: begin
              res_status_d = tkep_pkg::STAT_OK;
            end
            default: begin
              res_status_d = tkep_pkg::STAT_MISS;
            end
          endcase
        end
      end

      // Data of cur_q is on the read port; compare and move on.
      tkep_pkg::ST_WALK: begin
        if (hit) begin
          res_status_d = tkep_pkg::STAT_OK;
          res_key_d    = d_rdata[63:32];
          res_hnd_d    = d_rdata[31:0];
          slot_d       = cur_q;
          nxt_d        = n_rdata;
          prv_d        = p_rdata;
          if ((req_q == tkep_pkg::REQ_REM_KEY) || (req_q == tkep_pkg::REQ_REM_HND)) begin
            state_d = tkep_pkg::ST_RM_UNLINK;
          end else begin
            state_d = tkep_pkg::ST_EMIT;
          end
        end else if (n_rdata == tkep_pkg::NilLink) begin
          state_d = tkep_pkg::ST_EMIT;
        end else begin
          cur_d   = n_rdata;
          rd_addr = n_rdata[IdxW-1:0];
        end
      end

      tkep_pkg::ST_RM_UNLINK: begin
        if (prv_q == tkep_pkg::NilLink) begin
          head_d[type_q] = nxt_q;
        end else begin
          nw_en   = 1'b1;
          nw_addr = prv_q[IdxW-1:0];
          nw_data = nxt_q;
        end
        if (nxt_q != tkep_pkg::NilLink) begin
          pw_en   = 1'b1;
          pw_addr = nxt_q[IdxW-1:0];
          pw_data = prv_q;
        end
        state_d = tkep_pkg::ST_RM_FREE;
      end

      tkep_pkg::ST_RM_FREE: begin
        nw_en          = 1'b1;
        nw_data        = free_head_q;
        free_head_d    = slot_q;
        cnt_d[type_q]  = cnt_q[type_q] - CntW'(1);
        state_d        = tkep_pkg::ST_EMIT;
      end

      tkep_pkg::ST_INS_POP: begin
        slot_d      = cur_q;
        free_head_d = n_rdata;
        state_d     = tkep_pkg::ST_INS_LINK;
      end

      tkep_pkg::ST_INS_LINK: begin
        dw_en   = 1'b1;
        nw_en   = 1'b1;
        nw_data = cur_head;
        pw_en   = 1'b1;
        state_d = tkep_pkg::ST_INS_HEAD;
      end

      tkep_pkg::ST_INS_HEAD: begin
        if (cur_head != tkep_pkg::NilLink) begin
          pw_en   = 1'b1;
          pw_addr = cur_head[IdxW-1:0];
          pw_data = slot_q;
        end
        head_d[type_q] = slot_q;
        cnt_d[type_q]  = cnt_q[type_q] + CntW'(1);
        res_status_d   = tkep_pkg::STAT_OK;
        res_key_d      = key_q;
        res_hnd_d      = hnd_q;
        state_d        = tkep_pkg::ST_EMIT;
      end

      // Head entry cur_q is on the read port: report it, pop it, free it.
      tkep_pkg::ST_CLR: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_status_d   = tkep_pkg::STAT_OK;
          out_key_d      = d_rdata[63:32];
          out_hnd_d      = d_rdata[31:0];
          out_cnt_d      = cnt_q[type_q] - CntW'(1);
          out_last_d     = (n_rdata == tkep_pkg::NilLink);
          cnt_d[type_q]  = cnt_q[type_q] - CntW'(1);
          head_d[type_q] = n_rdata;
          nw_en          = 1'b1;
          nw_addr        = cur_q[IdxW-1:0];
          nw_data        = free_head_q;
          free_head_d    = cur_q;
          if (n_rdata == tkep_pkg::NilLink) begin
            state_d = tkep_pkg::ST_IDLE;
          end else begin
            pw_en   = 1'b1;
            pw_addr = n_rdata[IdxW-1:0];
            cur_d   = n_rdata;
            rd_addr = n_rdata[IdxW-1:0];
          end
        end
      end

      tkep_pkg::ST_EMIT: begin
        if (can_emit) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = res_key_q;
          out_hnd_d    = res_hnd_q;
          out_cnt_d    = cnt_q[type_q];
          out_last_d   = 1'b1;
          state_d      = tkep_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tkep_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkep_pkg::ST_IDLE;
      free_head_q <= tkep_pkg::NilLink;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < tkep_pkg::TypeLists; i++) begin
        head_q[i] <= tkep_pkg::NilLink;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    type_q       <= type_d;
    key_q        <= key_d;
    hnd_q        <= hnd_d;
    cur_q        <= cur_d;
    slot_q       <= slot_d;
    nxt_q        <= nxt_d;
    prv_q        <= prv_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_hnd_q    <= res_hnd_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_hnd_q    <= out_hnd_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.key_out    = out_key_q;
  assign rsp_o.handle_out = out_hnd_q;
  assign rsp_o.type_count = out_cnt_q;
  assign rsp_o.last       = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TKEP_ASSERT(a_fresh_range, fresh_q <= tkep_pkg::NilLink,
               "fill counter past pool size")
  `TKEP_ASSERT_IMP(a_ins_slot_valid, state_q == tkep_pkg::ST_INS_LINK,
                   slot_q != tkep_pkg::NilLink, "insert into null slot")
  `TKEP_ASSERT(a_rm_pushes_free, state_q == tkep_pkg::ST_RM_FREE |=>
               free_head_q == $past(slot_q), "removed entry not on free stack")
  `TKEP_ASSERT(a_emit_no_overwrite, out_valid_q && !rsp_o.ready |=>
               $stable(out_key_q) && $stable(out_last_q), "pending result overwritten")

endmodule

/* tb/tkep_tb_pkg.sv */
package tkep_tb_pkg;
  import tkep_pkg::*;

  typedef struct packed {
    req_e        req;
    logic [1:0]  etype;
    logic [31:0] key;
    logic [31:0] hnd;
  } pool_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] key;
    logic [31:0] hnd;
    logic [6:0]  cnt;
    logic        last;
  } pool_rsp_t;
endpackage

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tkep_pkg::*;
  import tkep_tb_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int RandItems  = 95;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  tkep_req_if req_if();
  tkep_rsp_if rsp_if();

  typed_keyed_entry_pool i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow of the pool: per-type lists kept as queues, newest at index 0.
  // A free count stands in for the free list; slot order never shows outside.
  logic [31:0] shadow_key[TypeLists][$];
  logic [31:0] shadow_hnd[TypeLists][$];
  int          free_slots = PoolEntries;

  pool_rsp_t pending_rsp[$];
  int        errors = 0;
  int        cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_rsp = 1'b0;

  function automatic pool_rsp_t mk_rsp(status_e st, logic [31:0] k, logic [31:0] h,
                                       int c, logic l);
    pool_rsp_t r;
    r.status = st; r.key = k; r.hnd = h; r.cnt = 7'(c); r.last = l;
    return r;
  endfunction

  // Appends one expected response at the tail of the queue.
  function automatic void expect_rsp(pool_rsp_t r);
    pending_rsp.insert(pending_rsp.size(), r);
  endfunction

  // Applies one request to the shadow pool and queues the responses it causes.
  task automatic predict_pool(pool_req_t r);
    int t;
    int n;
    int hit;
    logic [31:0] rk;
    logic [31:0] rh;
    t = r.etype;
    n = shadow_key[t].size();
    hit = -1;
    case (r.req)
      REQ_FIND_KEY, REQ_FIND_HND, REQ_REM_KEY, REQ_REM_HND: begin
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && (((r.req == REQ_FIND_HND || r.req == REQ_REM_HND)
                           ? shadow_hnd[t][i] : shadow_key[t][i]) ==
                          ((r.req == REQ_FIND_HND || r.req == REQ_REM_HND)
                           ? r.hnd : r.key)))
            hit = i;
        end
        if (hit < 0) begin
          expect_rsp(mk_rsp(STAT_MISS, '0, '0, n, 1'b1));
        end else begin
          rk = shadow_key[t][hit];
          rh = shadow_hnd[t][hit];
          if (r.req == REQ_REM_KEY || r.req == REQ_REM_HND) begin
            shadow_key[t].delete(hit);
            shadow_hnd[t].delete(hit);
            free_slots++;
          end
          expect_rsp(mk_rsp(STAT_OK, rk, rh, shadow_key[t].size(), 1'b1));
        end
      end
      REQ_INSERT: begin
        if (free_slots == 0) begin
          expect_rsp(mk_rsp(STAT_FULL, '0, '0, n, 1'b1));
        end else begin
          free_slots--;
          shadow_key[t].push_front(r.key);
          shadow_hnd[t].push_front(r.hnd);
          expect_rsp(mk_rsp(STAT_OK, r.key, r.hnd, n + 1, 1'b1));
        end
      end
      REQ_COUNT: expect_rsp(mk_rsp(STAT_OK, '0, '0, n, 1'b1));
      REQ_CLEAR: begin
        if (n == 0) expect_rsp(mk_rsp(STAT_MISS, '0, '0, 0, 1'b1));
        while (shadow_key[t].size() > 0) begin
          rk = shadow_key[t].pop_front();
          rh = shadow_hnd[t].pop_front();
          free_slots++;
          expect_rsp(mk_rsp(STAT_OK, rk, rh, shadow_key[t].size(),
                            shadow_key[t].size() == 0));
        end
      end
      default: expect_rsp(mk_rsp(STAT_MISS, '0, '0, n, 1'b1));
    endcase
  endtask

  // Directed table: expected value typed only where obvious; others use the shadow.
  typedef struct {
    pool_req_t r;
    bit        fixed;
    pool_rsp_t exp;
  } table_row_t;
  table_row_t dir_rows[$];

  function automatic void add_row(req_e q, int t, logic [31:0] k, logic [31:0] h,
                                  bit fx, pool_rsp_t e);
    table_row_t row;
    row.r.req = q; row.r.etype = 2'(t); row.r.key = k; row.r.hnd = h;
    row.fixed = fx; row.exp = e;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Sender: drives at the rising edge, waits for the handshake.
  // valid stays up after the handshake; gaps and drains drop it.
  task automatic send_req(pool_req_t r);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.req;
    req_if.entry_type <= r.etype;
    req_if.lookup_key <= r.key;
    req_if.handle_in  <= r.hnd;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Random content biased toward keys/handles already in the pool so that
  // hits and removes happen; a small key space also forces duplicates.
  function automatic pool_req_t rand_req();
    pool_req_t r;
    int t;
    int sel;
    t = $urandom_range(0, 3);
    sel = $urandom_range(0, 99);
    r.etype = 2'(t);
    r.key = (sel < 50) ? 32'($urandom_range(0, 15)) : $urandom;
    r.hnd = (sel < 50) ? 32'($urandom_range(100, 115)) : $urandom;
    if (shadow_key[t].size() > 0 && $urandom_range(0, 1)) begin
      int i;
      i = $urandom_range(0, shadow_key[t].size() - 1);
      r.key = shadow_key[t][i];
      r.hnd = shadow_hnd[t][i];
    end
    sel = $urandom_range(0, 99);
    if (sel < 40)      r.req = REQ_INSERT;
    else if (sel < 52) r.req = REQ_FIND_KEY;
    else if (sel < 64) r.req = REQ_FIND_HND;
    else if (sel < 76) r.req = REQ_REM_KEY;
    else if (sel < 88) r.req = REQ_REM_HND;
    else if (sel < 93) r.req = REQ_COUNT;
    else if (sel < 97) r.req = REQ_CLEAR;
    else               r.req = REQ_UNKNOWN;
    return r;
  endfunction

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk_i);
  endtask

  // Checker: compares every accepted response with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      pool_rsp_t got;
      pool_rsp_t exp;
      got.status = status_e'(rsp_if.status);
      got.key = rsp_if.key_out; got.hnd = rsp_if.handle_out;
      got.cnt = rsp_if.type_count; got.last = rsp_if.last;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
      end else begin
        exp = pending_rsp.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp, got);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the block.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = REQ_COUNT;
    req_if.entry_type = '0;
    req_if.lookup_key = '0;
    req_if.handle_in = '0;

    // After reset: every list empty, so the outcome is read off directly.
    add_row(REQ_COUNT,    0, 0, 0, 1, mk_rsp(STAT_OK,   '0, '0, 0, 1));
    add_row(REQ_FIND_KEY, 3, '1, 0, 1, mk_rsp(STAT_MISS, '0, '0, 0, 1));
    add_row(REQ_FIND_HND, 2, 0, '1, 1, mk_rsp(STAT_MISS, '0, '0, 0, 1));
    add_row(REQ_REM_KEY,  1, 0, 0, 1, mk_rsp(STAT_MISS, '0, '0, 0, 1));
    add_row(REQ_REM_HND,  0, 0, 0, 1, mk_rsp(STAT_MISS, '0, '0, 0, 1));
    add_row(REQ_CLEAR,    3, 0, 0, 1, mk_rsp(STAT_MISS, '0, '0, 0, 1));
    add_row(REQ_UNKNOWN,  1, '1, '1, 1, mk_rsp(STAT_MISS, '0, '0, 0, 1));
    add_row(REQ_INSERT,   0, '1, '1, 1, mk_rsp(STAT_OK,   '1, '1, 1, 1));
    add_row(REQ_INSERT,   0, 0, 0, 1, mk_rsp(STAT_OK,   '0, '0, 2, 1));
    // duplicate key: newest copy must be found first
    add_row(REQ_INSERT,   0, '1, 32'h5a5a_a5a5, 0, '0);
    add_row(REQ_FIND_KEY, 0, '1, 0, 0, '0);
    add_row(REQ_FIND_HND, 0, 0, '1, 0, '0);
    add_row(REQ_INSERT,   3, 32'h8000_0001, 32'h7fff_fffe, 0, '0);
    add_row(REQ_UNKNOWN,  0, 0, 0, 0, '0);
    add_row(REQ_REM_HND,  0, 0, '1, 0, '0);
    add_row(REQ_REM_KEY,  0, '1, 0, 0, '0);
    add_row(REQ_COUNT,    0, 0, 0, 0, '0);
    add_row(REQ_CLEAR,    0, 0, 0, 0, '0);
    add_row(REQ_CLEAR,    3, 0, 0, 0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every row updates the shadow; typed rows override the single expectation.
    foreach (dir_rows[i]) begin
      predict_pool(dir_rows[i].r);
      if (dir_rows[i].fixed) pending_rsp[pending_rsp.size() - 1] = dir_rows[i].exp;
      send_req(dir_rows[i].r);
      sender_gap();
    end

    // Fill the pool to the brim while the receiver holds off, then hit pool full.
    hold_rsp = 1'b1;
    for (int i = 0; i < PoolEntries + 2; i++) begin
      pool_req_t r;
      r.req = REQ_INSERT;
      r.etype = 2'($urandom_range(0, 3));
      r.key = $urandom;
      r.hnd = $urandom;
      predict_pool(r);
      send_req(r);
    end
    // Pause until every response is in.
    wait_drained();

    for (int i = 0; i < RandItems; i++) begin
      pool_req_t r;
      if (i == RandItems - 40) no_idle = 1'b1;
      r = rand_req();
      predict_pool(r);
      send_req(r);
      sender_gap();
    end
    for (int t = 0; t < TypeLists; t++) begin
      pool_req_t r;
      r.req = REQ_CLEAR; r.etype = 2'(t); r.key = '0; r.hnd = '0;
      predict_pool(r);
      send_req(r);
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
